/* rtl/pcx_pkg.sv */
// types, constants and codes shared by the pcx run-length palette decoder
`default_nettype none

package pcx_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_ADDR_BITS   = $clog2(PALETTE_ENTRIES);
	localparam int COLOR_BITS      = 24;
	localparam int CHAN_BITS       = 8;
	localparam int COORD_BITS      = 16;
	localparam int DIM_BITS        = 17;
	localparam int ROW_BITS        = 17;
	localparam int COUNT_BITS      = 6;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 17;

	localparam logic [7:0] MARKER_BITS = 8'hC0;
	localparam logic [7:0] COUNT_MASK  = 8'h3F;

	localparam logic CMD_PALETTE = 1'b0;
	localparam logic CMD_DATA    = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_BYTES   = 2'd2;

	typedef struct packed {
		logic pal_write;
		logic load_marker;
		logic clear_pending;
		logic start_run;
		logic step;
	} pcx_cmd_t;

	typedef struct packed {
		logic is_marker;
		logic image_done;
		logic zero_run;
		logic step_last;
		logic out_free;
	} pcx_status_t;

endpackage

`default_nettype wire

/* rtl/pcx_if.sv */
// channel interfaces: item input, pixel output and register write
`default_nettype none

interface pcx_item_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  palette_index;
	logic [23:0] palette_color;
	logic [7:0]  data_byte;

	modport source (output valid, command, palette_index, palette_color, data_byte,
		input ready);
	modport sink (input valid, command, palette_index, palette_color, data_byte,
		output ready);
endinterface

interface pcx_pixel_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [15:0] column;
	logic        end_of_row;
	logic        end_of_image;
	logic        last_of_run;

	modport source (output valid, red, green, blue, column, end_of_row, end_of_image,
		last_of_run, input ready);
	modport sink (input valid, red, green, blue, column, end_of_row, end_of_image,
		last_of_run, output ready);
endinterface

interface pcx_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/pcx_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module pcx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/pcx_ctrl.sv */
// decoder controller: item acceptance and run sequencing
`default_nettype none

module pcx_ctrl
	import pcx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire logic        item_command,
	output logic             item_ready,
	input  wire pcx_status_t st,
	output pcx_cmd_t         cmd
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t state_q;
	logic   accept;
	logic   data_item;

	always_comb begin
		item_ready        = (state_q == ST_IDLE);
		accept            = item_valid && item_ready;
		data_item         = accept && (item_command == CMD_DATA) && !st.image_done;
		cmd.pal_write     = accept && (item_command == CMD_PALETTE);
		cmd.load_marker   = data_item && st.is_marker;
		cmd.clear_pending = data_item && !st.is_marker && st.zero_run;
		cmd.start_run     = data_item && !st.is_marker && !st.zero_run;
		cmd.step          = (state_q == ST_RUN) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start_run) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.step && st.step_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.pal_write, cmd.load_marker, cmd.clear_pending, cmd.start_run,
			cmd.step}))
		else $error("more than one datapath action in a cycle");

	a_run_enters: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_run |=> (state_q == ST_RUN))
		else $error("run start did not enter run state");

	a_step_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && st.step_last) |=> item_ready)
		else $error("final step did not return to idle");

endmodule

`default_nettype wire

/* rtl/pcx_dp.sv */
// decoder datapath: registers, palette ram, position counters, output word
`default_nettype none

module pcx_dp
	import pcx_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire pcx_cmd_t                  cmd,
	output pcx_status_t                    st,
	input  wire logic [PAL_ADDR_BITS-1:0]  palette_index,
	input  wire logic [COLOR_BITS-1:0]     palette_color,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [CHAN_BITS-1:0]      red,
	output logic      [CHAN_BITS-1:0]      green,
	output logic      [CHAN_BITS-1:0]      blue,
	output logic      [COORD_BITS-1:0]     column,
	output logic                           end_of_row,
	output logic                           end_of_image,
	output logic                           last_of_run
);

	logic [DIM_BITS-1:0]   width_q;
	logic [DIM_BITS-1:0]   height_q;
	logic [COORD_BITS-1:0] line_bytes_q;
	logic [COORD_BITS-1:0] line_pos_q;
	logic [ROW_BITS-1:0]   row_q;
	logic                  pend_q;
	logic [COUNT_BITS-1:0] run_len_q;
	logic [COUNT_BITS-1:0] remain_q;
	logic                  out_valid_q;
	logic [COLOR_BITS-1:0] color_q;
	logic [COORD_BITS-1:0] column_q;
	logic                  eor_q;
	logic                  eoi_q;
	logic                  last_q;
	logic [COLOR_BITS-1:0] rd_color;

	logic [COORD_BITS:0]   pos_next;
	logic                  kept;
	logic                  row_done;
	logic                  eor;
	logic                  eoi;
	logic                  run_last;
	logic                  pix_last;

	pcx_ram #(
		.WIDTH (COLOR_BITS),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.wr_en   (cmd.pal_write),
		.wr_addr (palette_index),
		.wr_data (palette_color),
		.rd_en   (cmd.start_run),
		.rd_addr (data_byte[PAL_ADDR_BITS-1:0]),
		.rd_data (rd_color)
	);

	always_comb begin
		pos_next = {1'b0, line_pos_q} + 1'b1;
		kept     = {1'b0, line_pos_q} < width_q;
		row_done = pos_next >= {1'b0, line_bytes_q};
		eor      = pos_next == width_q;
		eoi      = eor && (({1'b0, row_q} + 1'b1) == {1'b0, height_q});
		run_last = (remain_q == COUNT_BITS'(1)) || row_done;
		pix_last = run_last || (pos_next >= width_q);

		st.is_marker  = !pend_q && ((data_byte & MARKER_BITS) == MARKER_BITS);
		st.image_done = row_q >= height_q;
		st.zero_run   = pend_q && (run_len_q == '0);
		st.step_last  = run_last;
		st.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= DIM_BITS'(1);
			height_q     <= DIM_BITS'(1);
			line_bytes_q <= '0;
			line_pos_q   <= '0;
			row_q        <= '0;
			pend_q       <= 1'b0;
			run_len_q    <= '0;
			remain_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_q      <= cfg_data[DIM_BITS-1:0];
					REG_IMAGE_HEIGHT: height_q     <= cfg_data[DIM_BITS-1:0];
					REG_LINE_BYTES:   line_bytes_q <= cfg_data[COORD_BITS-1:0];
					default: ;
				endcase
			end
			if (cmd.load_marker) begin
				pend_q    <= 1'b1;
				run_len_q <= data_byte[COUNT_BITS-1:0] & COUNT_MASK[COUNT_BITS-1:0];
			end
			if (cmd.clear_pending || cmd.start_run) begin
				pend_q    <= 1'b0;
				run_len_q <= '0;
			end
			if (cmd.start_run) begin
				remain_q <= pend_q ? run_len_q : COUNT_BITS'(1);
			end
			if (cmd.step) begin
				remain_q <= remain_q - 1'b1;
				if (row_done) begin
					line_pos_q <= '0;
					row_q      <= row_q + 1'b1;
				end else begin
					line_pos_q <= pos_next[COORD_BITS-1:0];
				end
			end
			if (cmd.step && kept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && kept) begin
			color_q  <= rd_color;
			column_q <= line_pos_q;
			eor_q    <= eor;
			eoi_q    <= eoi;
			last_q   <= pix_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = color_q[23:16];
	assign green        = color_q[15:8];
	assign blue         = color_q[7:0];
	assign column       = column_q;
	assign end_of_row   = eor_q;
	assign end_of_image = eoi_q;
	assign last_of_run  = last_q;

	a_step_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (!out_valid_q || out_ready))
		else $error("step taken while output word still held");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (remain_q != '0))
		else $error("step with no repeat left");

	a_run_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_run |=> (remain_q != '0) && !pend_q)
		else $error("run started with empty count");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && row_done) |=> (line_pos_q == '0))
		else $error("line position not restarted at row end");

endmodule

`default_nettype wire

/* rtl/pcx_rle_palette_decoder.sv */
// top level of the pcx run-length decoder with palette expansion
//
//   channel  dir  word                                   ready rule
//   item     in   command, palette index/colour, byte    high while no run is in progress
//   pixel    out  red, green, blue, column, flags        from the consumer
//   cfg      in   register index, data                   always high
//
// a palette write, a run marker or an ignored byte is taken without starting a run
// a literal or run byte reads the palette and then decodes up to 63 positions, fewer at a row end;
// after the palette read, the position counter steps whenever the output word is free
// arst_n clears counters, sets width and height to 1 and drops output valid; the palette is not cleared
// a held output word stalls the run; no item is taken until the run ends
`default_nettype none

module pcx_rle_palette_decoder
	import pcx_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pcx_item_if.sink  item,
	pcx_pixel_if.source pixel,
	pcx_cfg_if.sink   cfg
);

	pcx_cmd_t    cmd;
	pcx_status_t st;

	assign cfg.ready = 1'b1;

	pcx_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_command (item.command),
		.item_ready   (item.ready),
		.st           (st),
		.cmd          (cmd)
	);

	pcx_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.palette_index (item.palette_index),
		.palette_color (item.palette_color),
		.data_byte     (item.data_byte),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.out_valid     (pixel.valid),
		.out_ready     (pixel.ready),
		.red           (pixel.red),
		.green         (pixel.green),
		.blue          (pixel.blue),
		.column        (pixel.column),
		.end_of_row    (pixel.end_of_row),
		.end_of_image  (pixel.end_of_image),
		.last_of_run   (pixel.last_of_run)
	);

endmodule

`default_nettype wire
